/* rtl/spongent_pkg.sv */
package spongent_pkg;

  localparam int unsigned STATE_W   = 176;
  localparam int unsigned STATE_W_S = 160;
  localparam int unsigned LFSR_W    = 7;
  localparam int unsigned CNT_W     = 7;

  localparam logic [LFSR_W-1:0] LFSR_INIT_160 = 7'h75;
  localparam logic [LFSR_W-1:0] LFSR_INIT_176 = 7'h45;

  localparam logic [CNT_W-1:0] ROUNDS_160 = 7'd80;
  localparam logic [CNT_W-1:0] ROUNDS_176 = 7'd90;

  localparam logic VARIANT_160 = 1'b0;
  localparam logic VARIANT_176 = 1'b1;

  typedef struct packed {
    logic [47:0] state_high;
    logic [63:0] state_mid;
    logic [63:0] state_low;
  } state_in_t;

  typedef struct packed {
    logic [47:0] result_high;
    logic [63:0] result_mid;
    logic [63:0] result_low;
  } state_out_t;

  typedef struct packed {
    logic load;
    logic step;
  } dp_cmd_t;

  typedef struct packed {
    logic mode;
  } dp_stat_t;

  function automatic logic [3:0] sbox4(input logic [3:0] x);
    logic [3:0] y;
    unique case (x)
      4'h0: y = 4'hE;
      4'h1: y = 4'hD;
      4'h2: y = 4'hB;
      4'h3: y = 4'h0;
      4'h4: y = 4'h2;
      4'h5: y = 4'h1;
      4'h6: y = 4'h4;
      4'h7: y = 4'hF;
      4'h8: y = 4'h7;
      4'h9: y = 4'hA;
      4'hA: y = 4'h8;
      4'hB: y = 4'h5;
      4'hC: y = 4'h9;
      4'hD: y = 4'hC;
      4'hE: y = 4'h3;
      default: y = 4'h6;
    endcase
    return y;
  endfunction

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[7-k] = v[k];
    end
    return r;
  endfunction

endpackage

/* rtl/spongent_ctrl.sv */
module spongent_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  output logic                  done_o,
  output spongent_pkg::dp_cmd_t cmd_o,
  input  spongent_pkg::dp_stat_t stat_i
);

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_RUN  = 1'b1;

  logic [0:0]                     state_q, state_d;
  logic [spongent_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                           done_q, done_d;
  logic [spongent_pkg::CNT_W-1:0] last_cnt;
  logic                           last_round;

  assign busy     = (state_q == ST_RUN);
  assign done_o   = done_q;
  assign last_cnt = (stat_i.mode == spongent_pkg::VARIANT_176)
                  ? spongent_pkg::ROUNDS_176 - 7'd1
                  : spongent_pkg::ROUNDS_160 - 7'd1;
  assign last_round = (cnt_q == last_cnt);

  assign cmd_o.load = start && !busy;
  assign cmd_o.step = busy;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_RUN;
          cnt_d   = '0;
        end
      end
      default: begin
        if (last_round) begin
          state_d = ST_IDLE;
          done_d  = 1'b1;
        end else begin
          cnt_d = cnt_q + 7'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  a_accept_runs : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && cnt_q == '0))
    else $error("accepted beat did not start the round loop");

  a_done_ends_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(busy) && !busy))
    else $error("done without a finished round loop");

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (cnt_q < spongent_pkg::ROUNDS_176))
    else $error("round counter out of range");

  a_last_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && last_round) |=> done_o)
    else $error("last round not followed by done");

endmodule

/* rtl/spongent_dp.sv */
module spongent_dp (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_wdata_i,
  input  spongent_pkg::state_in_t in_i,
  output spongent_pkg::state_out_t result_o,
  input  spongent_pkg::dp_cmd_t   cmd_i,
  output spongent_pkg::dp_stat_t  stat_o
);

  localparam int unsigned W  = spongent_pkg::STATE_W;
  localparam int unsigned WS = spongent_pkg::STATE_W_S;

  logic                            variant_q;
  logic                            mode_q;
  logic [spongent_pkg::LFSR_W-1:0] lfsr_q;
  logic [W-1:0]                    state_q;

  logic [7:0]    rc;
  logic [7:0]    rv;
  logic [WS-1:0] x160, s160, p160;
  logic [W-1:0]  x176, s176, p176;
  logic [W-1:0]  round_out;
  logic [47:0]   load_high;

  assign rc = {1'b0, lfsr_q};
  assign rv = spongent_pkg::rev8(rc);

  assign x160 = state_q[WS-1:0] ^ {rv, {(WS-16){1'b0}}, rc};
  assign x176 = state_q ^ {rv, {(W-16){1'b0}}, rc};

  for (genvar n = 0; n < WS / 4; n++) begin : g_sb160
    assign s160[4*n +: 4] = spongent_pkg::sbox4(x160[4*n +: 4]);
  end
  for (genvar n = 0; n < W / 4; n++) begin : g_sb176
    assign s176[4*n +: 4] = spongent_pkg::sbox4(x176[4*n +: 4]);
  end

  for (genvar i = 0; i < WS; i++) begin : g_pm160
    localparam int unsigned D = (i == WS - 1) ? WS - 1 : (i * (WS / 4)) % (WS - 1);
    assign p160[D] = s160[i];
  end
  for (genvar i = 0; i < W; i++) begin : g_pm176
    localparam int unsigned D = (i == W - 1) ? W - 1 : (i * (W / 4)) % (W - 1);
    assign p176[D] = s176[i];
  end

  assign round_out = (mode_q == spongent_pkg::VARIANT_176) ? p176 : {16'b0, p160};
  assign load_high = (variant_q == spongent_pkg::VARIANT_176)
                   ? in_i.state_high : {16'b0, in_i.state_high[31:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      variant_q <= spongent_pkg::VARIANT_160;
      mode_q    <= spongent_pkg::VARIANT_160;
    end else begin
      if (cfg_we_i) begin
        variant_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        mode_q <= variant_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      state_q <= {load_high, in_i.state_mid, in_i.state_low};
      lfsr_q  <= (variant_q == spongent_pkg::VARIANT_176)
               ? spongent_pkg::LFSR_INIT_176 : spongent_pkg::LFSR_INIT_160;
    end else if (cmd_i.step) begin
      state_q <= round_out;
      lfsr_q  <= {lfsr_q[5:0], lfsr_q[6] ^ lfsr_q[5]};
    end
  end

  assign result_o.result_low  = state_q[63:0];
  assign result_o.result_mid  = state_q[127:64];
  assign result_o.result_high = state_q[175:128];
  assign stat_o.mode          = mode_q;

endmodule

/* rtl/spongent_pi_permutation.sv */
// Spongent-pi permutation, 160-bit/80-round or 176-bit/90-round form, chosen by
// the one-bit variant register (cfg_we_i/cfg_wdata_i, write only while idle).
// A beat is taken when start is high and busy is low; the round loop then runs
// one round per clock, and at its end done_o pulses for exactly one cycle with
// the result on result_o and busy drops in that same cycle; no new beat is
// taken while busy is high. The receiver cannot stall: capture result_o while
// done_o is high; it holds only until the next beat is taken. In 160-bit mode
// the top 16 input bits are ignored and returned as zero.
module spongent_pi_permutation (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_wdata_i,
  input  logic                     start,
  output logic                     busy,
  input  spongent_pkg::state_in_t  in_i,
  output logic                     done_o,
  output spongent_pkg::state_out_t result_o
);

  spongent_pkg::dp_cmd_t  cmd;
  spongent_pkg::dp_stat_t stat;

  spongent_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd),
    .stat_i (stat)
  );

  spongent_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .result_o    (result_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

/* verif/spongent_pi_permutation_tb.sv */
`timescale 1ns / 100ps

module spongent_pi_permutation_tb;

  localparam logic [3:0] SUB_TABLE [16] = '{
    4'hE, 4'hD, 4'hB, 4'h0, 4'h2, 4'h1, 4'h4, 4'hF,
    4'h7, 4'hA, 4'h8, 4'h5, 4'h9, 4'hC, 4'h3, 4'h6
  };

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic                     cfg_wdata_i;
  logic                     start;
  logic                     busy;
  spongent_pkg::state_in_t  in_i;
  logic                     done_o;
  spongent_pkg::state_out_t result_o;

  logic                     variant_r;
  spongent_pkg::state_out_t permuted_q[$];
  int                       mismatch_cnt;

  spongent_pi_permutation DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start       (start),
    .busy        (busy),
    .in_i        (in_i),
    .done_o      (done_o),
    .result_o    (result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic spongent_pkg::state_out_t spongent_permute(input logic [175:0] din,
                                                                input logic wide);
    logic [175:0] st;
    logic [175:0] nx;
    logic [6:0]   rc;
    logic [7:0]   rc_byte;
    logic [7:0]   rc_rev;
    int           width;
    int           rounds;
    int           mul;
    st     = din;
    width  = wide ? spongent_pkg::STATE_W : spongent_pkg::STATE_W_S;
    rounds = wide ? int'(spongent_pkg::ROUNDS_176) : int'(spongent_pkg::ROUNDS_160);
    rc     = wide ? spongent_pkg::LFSR_INIT_176 : spongent_pkg::LFSR_INIT_160;
    mul    = width / 4;
    if (!wide) begin
      st[175:160] = '0;
    end
    for (int r = 0; r < rounds; r++) begin
      rc_byte = {1'b0, rc};
      for (int k = 0; k < 8; k++) begin
        rc_rev[7-k] = rc_byte[k];
      end
      for (int k = 0; k < 8; k++) begin
        st[k]           = st[k] ^ rc_byte[k];
        st[width-8+k]   = st[width-8+k] ^ rc_rev[k];
      end
      rc = {rc[5:0], rc[6] ^ rc[5]};
      for (int i = 0; i < width; i += 4) begin
        st[i+:4] = SUB_TABLE[st[i+:4]];
      end
      nx = '0;
      for (int i = 0; i < width - 1; i++) begin
        nx[(i * mul) % (width - 1)] = st[i];
      end
      nx[width-1] = st[width-1];
      st = nx;
    end
    return spongent_pkg::state_out_t'(st);
  endfunction

  function automatic logic [175:0] rand_state();
    logic [175:0] v;
    v = 176'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    case ($urandom_range(0, 15))
      0: v[63:0]    = '0;
      1: v[127:64]  = '1;
      2: v[175:128] = '1;
      3: v[175:128] = '0;
      default: ;
    endcase
    return v;
  endfunction

  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 200);
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
    if (mismatch_cnt < 10) begin
      $display("ERROR %0t: %s expected %h got %h", $time, what, exp_v, act_v);
    end
    mismatch_cnt++;
  endtask

  always @(posedge clk_i) begin : result_check
    spongent_pkg::state_out_t exp_r;
    if (rst_ni && done_o) begin
      if (permuted_q.size() == 0) begin
        flag_mismatch("unexpected result_low", '0, result_o.result_low);
      end else begin
        exp_r = permuted_q.pop_front();
        if (result_o.result_low !== exp_r.result_low)
          flag_mismatch("result_low", exp_r.result_low, result_o.result_low);
        if (result_o.result_mid !== exp_r.result_mid)
          flag_mismatch("result_mid", exp_r.result_mid, result_o.result_mid);
        if (result_o.result_high !== exp_r.result_high)
          flag_mismatch("result_high", 64'(exp_r.result_high), 64'(result_o.result_high));
      end
    end
  end

  task automatic send_state(input logic [175:0] bits);
    start <= 1'b1;
    in_i  <= spongent_pkg::state_in_t'(bits);
    do @(posedge clk_i); while (busy);
    permuted_q.push_back(spongent_permute(bits, variant_r));
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic wait_drain();
    start <= 1'b0;
    while (permuted_q.size() != 0 || busy) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_variant(input logic v);
    wait_drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    variant_r = v;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_directed_edges();
    logic [175:0] pick;
    for (int m = 0; m < 2; m++) begin
      write_variant(m[0]);
      send_state('0);
      send_state('1);
      send_state(176'd1);
      send_state(176'd1 << 159);
      send_state(176'd1 << 175);
      send_state({88{2'b01}});
      send_state({88{2'b10}});
      pick = rand_state();
      pick[175:160] = '0;
      send_state(pick);
      idle_gap(3);
      pick[175:160] = 16'hFFFF;
      send_state(pick);
      pick[175:160] = 16'hA5C3;
      send_state(pick);
    end
  endtask

  task automatic test_random_mixed(input int per_phase);
    for (int p = 0; p < 4; p++) begin
      write_variant(p[0]);
      for (int n = 0; n < per_phase; n++) begin
        send_state(rand_state());
        if (n == per_phase / 2) begin
          wait_drain();
        end else begin
          idle_gap(gap_cycles());
        end
      end
    end
  endtask

  task automatic test_back_to_back(input int per_mode);
    for (int m = 1; m >= 0; m--) begin
      write_variant(m[0]);
      for (int n = 0; n < per_mode; n++) begin
        send_state(rand_state());
      end
    end
  endtask

  initial begin
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = 1'b0;
    start        = 1'b0;
    in_i         = '0;
    variant_r    = spongent_pkg::VARIANT_160;
    mismatch_cnt = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_edges();
    test_random_mixed(250);
    test_back_to_back(100);

    wait_drain();
    repeat (100) @(posedge clk_i);
    if (mismatch_cnt == 0 && permuted_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

/* filelist.f */
rtl/spongent_pkg.sv
rtl/spongent_ctrl.sv
rtl/spongent_dp.sv
rtl/spongent_pi_permutation.sv
verif/spongent_pi_permutation_tb.sv
